[src/audio_energy_meter_assert.svh]
// Assertion macros used by the audio energy meter controller.
`ifndef AUDIO_ENERGY_METER_ASSERT_SVH
`define AUDIO_ENERGY_METER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AEM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("audio_energy_meter: assertion failed");

// Next-cycle implication, disabled during reset.
`define AEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("audio_energy_meter: assertion failed");

`endif

[src/aem_pkg.sv]
// Types, constants and helper function for the audio energy meter.
package aem_pkg;

    localparam int GROUP_SIZE = 32;
    localparam int RING_DEPTH = 1024;

    localparam int SMP_W   = 16;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 8;
    localparam int SLOT_W  = 10;
    localparam int DB_W    = 9;
    localparam int LVL_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int P_W     = 6;
    localparam int LOG_W   = P_W + FRAC_W;
    localparam int MANT_W  = 32;
    localparam int PROD_W  = 2 * MANT_W;
    localparam int ATT_W   = 40;
    localparam int NUM_W   = DB_W + FRAC_W;
    localparam int SQ_STEPS  = FRAC_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CTR_W   = $clog2(DIV_STEPS);

    localparam logic signed [DB_W-1:0] MIN_DB_RESET = -9'sd90;
    localparam logic [17:0]          DB_PER_LOG2  = 18'd197283;
    localparam logic [LVL_W-1:0]     LVL_MAX      = {LVL_W{1'b1}};
    localparam logic [SUM_W-1:0]     FULL_SUM     = SUM_W'(GROUP_SIZE) << 30;

    // 6.16 log2, evaluated at elaboration only.
    function automatic logic [LOG_W-1:0] log2_q16_const(input longint unsigned x);
        int unsigned       p;
        longint unsigned   m;
        logic [FRAC_W-1:0] fr;
        p  = 0;
        fr = '0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        if (p >= 31) m = x >> (p - 31);
        else         m = x << (31 - p);
        for (int i = 0; i < FRAC_W; i++) begin
            m  = (m * m) >> 31;
            fr = {fr[FRAC_W-2:0], 1'b0};
            if (m >= 64'h1_0000_0000) begin
                fr[0] = 1'b1;
                m     = m >> 1;
            end
        end
        return {P_W'(p), fr};
    endfunction

    // log2(GROUP_SIZE) + 30, the reference point of the attenuation
    localparam logic [LOG_W-1:0] LOG_REF =
        log2_q16_const(longint'(GROUP_SIZE)) + LOG_W'(30 << FRAC_W);

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic signed [15:0]      beam_angle;
        logic [15:0]             beam_confidence;
    } t_in;

    typedef struct packed {
        logic [LVL_W-1:0]   energy_level;
        logic [SLOT_W-1:0]  ring_slot;
        logic signed [15:0] angle_out;
        logic [15:0]        confidence_out;
    } t_out;

    typedef struct packed {
        logic accept;
        logic chk_load;
        logic norm_shift;
        logic m_load;
        logic sq_mul;
        logic sq_upd;
        logic att_mul;
        logic att_reg;
        logic div_load;
        logic div_step;
        logic lvl_zero;
        logic lvl_full;
        logic lvl_sat;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic sum_zero;
        logic sum_full;
        logic floor_bad;
        logic norm_done;
        logic a_ge_floor;
        logic out_free;
    } t_sts;

endpackage

[src/aem_dp.sv]
// Datapath: square accumulator, log2 unit, dB scaling, divider, output register.
module aem_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aem_pkg::t_in          i_in,
    input  logic                  i_cfg_we,
    input  logic [8:0]            i_cfg_data,
    input  aem_pkg::t_cmd         i_cmd,
    output aem_pkg::t_sts         o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output aem_pkg::t_out         o_out
);
    import aem_pkg::*;

    logic signed [DB_W-1:0]  r_min_db;
    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic [SLOT_W-1:0]       r_slot;
    logic signed [15:0]      r_angle;
    logic [15:0]             r_conf;
    logic [SUM_W-1:0]        r_x;
    logic [P_W-1:0]          r_p;
    logic [MANT_W-1:0]       r_m;
    logic [FRAC_W-1:0]       r_frac;
    logic [PROD_W-1:0]       r_prod;
    logic [NUM_W-1:0]        r_a;
    logic [DB_W-1:0]         r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic [LVL_W-1:0]        r_level;
    logic                    r_out_valid;
    t_out                    r_out;

    logic signed [2*SMP_W-1:0] w_sq;
    logic                      w_last;
    logic [LOG_W-1:0]          w_log;
    logic [LOG_W-1:0]          w_d;
    logic [ATT_W-1:0]          w_att;
    logic [DB_W-1:0]           w_f;
    logic [NUM_W-1:0]          w_fq;
    logic [DB_W:0]             w_rem_sh;
    logic                      w_q_bit;
    logic [SLOT_W:0]           w_slot_inc;

    assign w_sq   = (2*SMP_W)'(i_in.sample) * (2*SMP_W)'(i_in.sample);
    assign w_last = ({1'b0, r_cnt} + (CNT_W+1)'(1)) >= (CNT_W+1)'(GROUP_SIZE);

    assign w_log = {r_p, r_frac};
    assign w_d   = (w_log < LOG_REF) ? (LOG_REF - w_log) : '0;
    assign w_att = ATT_W'(w_d) * ATT_W'(DB_PER_LOG2);

    // floor magnitude, 1..256 when the register is negative
    assign w_f  = ~r_min_db + DB_W'(1);
    assign w_fq = {w_f, {FRAC_W{1'b0}}};

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_q_bit  = w_rem_sh >= {1'b0, w_f};

    assign w_slot_inc = {1'b0, r_slot} + (SLOT_W+1)'(1);

    assign o_sts.last       = w_last;
    assign o_sts.sum_zero   = (r_sum == '0);
    assign o_sts.sum_full   = (r_sum >= FULL_SUM);
    assign o_sts.floor_bad  = ~r_min_db[DB_W-1];
    assign o_sts.norm_done  = r_x[SUM_W-1];
    assign o_sts.a_ge_floor = (r_a >= w_fq);
    assign o_sts.out_free   = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_db    <= MIN_DB_RESET;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_db <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_sum <= r_sum + {{(SUM_W-2*SMP_W){1'b0}}, w_sq};
                r_cnt <= w_last ? '0 : r_cnt + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_sum       <= '0;
                r_out_valid <= 1'b1;
                if (w_slot_inc >= (SLOT_W+1)'(RING_DEPTH)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= w_slot_inc[SLOT_W-1:0];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_angle <= i_in.beam_angle;
            r_conf  <= i_in.beam_confidence;
        end
        if (i_cmd.chk_load) begin
            r_x <= r_sum;
            r_p <= P_W'(SUM_W - 1);
        end else if (i_cmd.norm_shift) begin
            r_x <= {r_x[SUM_W-2:0], 1'b0};
            r_p <= r_p - P_W'(1);
        end
        if (i_cmd.m_load) begin
            r_m    <= r_x[SUM_W-1 -: MANT_W];
            r_frac <= '0;
        end else if (i_cmd.sq_upd) begin
            // product >= 2 in Q2.62: emit a one and renormalize
            r_frac <= {r_frac[FRAC_W-2:0], r_prod[PROD_W-1]};
            r_m    <= r_prod[PROD_W-1] ? r_prod[PROD_W-1 -: MANT_W]
                                       : r_prod[PROD_W-2 -: MANT_W];
        end
        if (i_cmd.sq_mul) begin
            r_prod <= PROD_W'(r_m) * PROD_W'(r_m);
        end else if (i_cmd.att_mul) begin
            r_prod <= PROD_W'(w_att);
        end
        if (i_cmd.att_reg) begin
            r_a <= NUM_W'(({1'b0, r_prod[ATT_W-1:0]} + (ATT_W+1)'(32768)) >> FRAC_W);
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= w_fq - r_a;
        end else if (i_cmd.div_step) begin
            r_rem <= w_q_bit ? DB_W'(w_rem_sh - {1'b0, w_f}) : w_rem_sh[DB_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_q_bit};
        end
        if (i_cmd.lvl_zero) begin
            r_level <= '0;
        end else if (i_cmd.lvl_full) begin
            r_level <= LVL_MAX;
        end else if (i_cmd.lvl_sat) begin
            r_level <= (|r_quo[NUM_W-1:LVL_W]) ? LVL_MAX : r_quo[LVL_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.energy_level   <= r_level;
            r_out.ring_slot      <= r_slot;
            r_out.angle_out      <= r_angle;
            r_out.confidence_out <= r_conf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[src/aem_ctrl.sv]
// Controller: sequences accumulation, log, scaling and division per group.
`include "audio_energy_meter_assert.svh"

module aem_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  aem_pkg::t_sts  i_sts,
    output aem_pkg::t_cmd  o_cmd
);
    import aem_pkg::*;

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_NORM  = 4'd2;
    localparam logic [3:0] S_SQMUL = 4'd3;
    localparam logic [3:0] S_SQUPD = 4'd4;
    localparam logic [3:0] S_AMUL  = 4'd5;
    localparam logic [3:0] S_AREG  = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_SAT   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CTR_W-1:0] r_cnt, n_cnt;
    t_cmd             w_cmd;

    assign o_in_ready = (r_state == S_ACC);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        case (r_state)
            S_ACC: begin
                w_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.last) n_state = S_CHK;
            end
            S_CHK: begin
                w_cmd.chk_load = 1'b1;
                if (i_sts.sum_zero || i_sts.floor_bad) begin
                    w_cmd.lvl_zero = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.sum_full) begin
                    w_cmd.lvl_full = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_sts.norm_done) begin
                    w_cmd.m_load = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_SQMUL;
                end else begin
                    w_cmd.norm_shift = 1'b1;
                end
            end
            S_SQMUL: begin
                w_cmd.sq_mul = 1'b1;
                n_state      = S_SQUPD;
            end
            S_SQUPD: begin
                w_cmd.sq_upd = 1'b1;
                if (r_cnt == CTR_W'(SQ_STEPS - 1)) begin
                    n_state = S_AMUL;
                end else begin
                    n_cnt   = r_cnt + CTR_W'(1);
                    n_state = S_SQMUL;
                end
            end
            S_AMUL: begin
                w_cmd.att_mul = 1'b1;
                n_state       = S_AREG;
            end
            S_AREG: begin
                w_cmd.att_reg = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                if (i_sts.a_ge_floor) begin
                    w_cmd.lvl_zero = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    w_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == CTR_W'(DIV_STEPS - 1)) begin
                    n_state = S_SAT;
                end else begin
                    n_cnt = r_cnt + CTR_W'(1);
                end
            end
            S_SAT: begin
                w_cmd.lvl_sat = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd = w_cmd;

    `AEM_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, i_sts.out_free)
    `AEM_ASSERT_NEXT(a_back_to_acc, i_clk, i_rst_n, w_cmd.out_load, r_state == S_ACC)
    `AEM_ASSERT_NEXT(a_last_starts_calc, i_clk, i_rst_n, w_cmd.accept && i_sts.last, r_state == S_CHK)
    `AEM_ASSERT_NOW(a_div_cnt_bound, i_clk, i_rst_n, r_state == S_DIV, r_cnt < CTR_W'(DIV_STEPS))

endmodule

[src/audio_energy_meter.sv]
// Top level of the audio energy meter.
//
// Samples are taken one per cycle while a group is being summed; each group of
// GROUP_SIZE (32) samples yields one result: the Q0.16 level 1 - dB/floor of the
// group's mean square, the ring slot and the beam values of the group's last
// sample. After the last sample of a group the input stalls while the result is
// computed: special-case checks, one-bit normalizing shifts, a mantissa load, the
// 16 squarings of the log2 mantissa on one 32x32 multiplier, dB scaling and floor
// compare, a restoring divider by the floor, then saturation and hand-over; a
// group at or below the floor skips the divider and saturation, and silent,
// full-scale or floor-disabled groups go from the checks straight to hand-over.
// Hand-over waits while the previous result is still unread. The result sits in
// an output register, so a new group may be summed while it waits. The floor
// register (i_cfg_we / i_cfg_data, signed whole dB, reset -90) is to be written
// only between groups.
module audio_energy_meter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  aem_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output aem_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_data
);
    import aem_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    aem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    aem_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the audio energy meter: grouped samples in, checked levels out.
module tb;
    import aem_pkg::*;

    localparam int SETTLE_CYCLES   = 200;        // beyond the longest group computation
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam logic [63:0] DB_PER_DOUBLING = 64'd197283;   // 10*log10(2), Q.16

    typedef enum int {
        GRP_SILENT, GRP_LOUD, GRP_PEAK, GRP_TINY, GRP_RANDOM, GRP_MIXED
    } t_group_kind;

    class meter_scoreboard;
        logic signed [DB_W-1:0] floor_db;
        logic [SUM_W-1:0]       square_acc;
        logic [CNT_W-1:0]       sample_count;
        logic [SLOT_W-1:0]      next_slot;
        t_out                   levels_due[$];
        int                     errors;
        int                     groups_checked;
        int                     slot_wraps;

        function new();
            floor_db       = -9'sd90;
            square_acc     = '0;
            sample_count   = '0;
            next_slot      = '0;
            errors         = 0;
            groups_checked = 0;
            slot_wraps     = 0;
        endfunction

        function void set_floor(input logic signed [DB_W-1:0] v);
            floor_db = v;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // 6.16 log2: integer part from the top set bit, 16 fraction bits by squaring
        function logic [21:0] log2_fixed(input logic [63:0] x);
            int          p;
            int          i;
            logic [63:0] m;
            logic [15:0] fr;
            p  = 63;
            fr = '0;
            while (p > 0 && !x[p]) p--;
            if (p >= 31) m = x >> (p - 31);
            else         m = x << (31 - p);
            for (i = 0; i < 16; i++) begin
                m  = (m * m) >> 31;
                fr = {fr[14:0], 1'b0};
                if (m >= 64'h1_0000_0000) begin
                    fr[0] = 1'b1;
                    m     = m >> 1;
                end
            end
            return {p[5:0], fr};
        endfunction

        function logic [LVL_W-1:0] group_level(input logic [SUM_W-1:0] s);
            int          f;
            logic [63:0] full_sum;
            logic [63:0] ref_log;
            logic [63:0] att;
            logic [63:0] fq;
            logic [63:0] lvl;
            f        = -int'(floor_db);
            full_sum = 64'(GROUP_SIZE) << 30;
            if (f <= 0 || s == '0) return '0;
            if (64'(s) >= full_sum) return 16'hFFFF;
            ref_log = 64'(log2_fixed(64'(GROUP_SIZE))) + (64'd30 << 16);
            att     = 64'(log2_fixed(64'(s)));
            att     = (ref_log > att) ? ref_log - att : 64'd0;
            att     = (att * DB_PER_DOUBLING + 64'd32768) >> 16;
            fq      = 64'(f) << 16;
            if (att >= fq) return '0;
            lvl = (fq - att) / 64'(f);
            if (lvl > 64'd65535) lvl = 64'd65535;
            return lvl[15:0];
        endfunction

        function void note_input(input t_in w);
            logic signed [31:0] s32;
            logic [31:0]        sq;
            t_out               r;
            int                 nxt;
            s32        = 32'(w.sample);
            sq         = s32 * s32;
            square_acc = square_acc + SUM_W'(sq);
            if (int'(sample_count) + 1 < GROUP_SIZE) begin
                sample_count = sample_count + 1'b1;
                return;
            end
            r.energy_level   = group_level(square_acc);
            r.ring_slot      = next_slot;
            r.angle_out      = w.beam_angle;
            r.confidence_out = w.beam_confidence;
            levels_due.push_back(r);
            nxt = int'(next_slot) + 1;
            if (nxt >= RING_DEPTH) nxt = 0;
            next_slot    = nxt[SLOT_W-1:0];
            square_acc   = '0;
            sample_count = '0;
        endfunction

        function void check_result(input t_out got);
            t_out exp;
            if (levels_due.size() == 0) begin
                $error("result word with no group pending: level %0d slot %0d",
                       got.energy_level, got.ring_slot);
                errors++;
                return;
            end
            exp = levels_due.pop_front();
            if (got.energy_level !== exp.energy_level) begin
                $error("energy_level: expected %0d, got %0d", exp.energy_level, got.energy_level);
                errors++;
            end
            if (got.ring_slot !== exp.ring_slot) begin
                $error("ring_slot: expected %0d, got %0d", exp.ring_slot, got.ring_slot);
                errors++;
            end
            if (got.angle_out !== exp.angle_out) begin
                $error("angle_out: expected %0d, got %0d", exp.angle_out, got.angle_out);
                errors++;
            end
            if (got.confidence_out !== exp.confidence_out) begin
                $error("confidence_out: expected %0d, got %0d",
                       exp.confidence_out, got.confidence_out);
                errors++;
            end
            if (exp.ring_slot == '0 && groups_checked > 0) slot_wraps++;
            groups_checked++;
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   in_valid = 1'b0;
    t_in                    in_data  = '0;
    logic                   out_ready = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [DB_W-1:0]        cfg_data = '0;
    logic                   in_ready;
    logic                   out_valid;
    t_out                   out_data;

    meter_scoreboard sb = new();

    int  burst_left  = 0;
    int  gap_max     = 0;
    int  stall_mode  = 0;
    int  stall_left  = 0;
    int  cycles      = 0;
    int  words_sent  = 0;
    int  groups_sent = 0;
    int  floors_set  = 0;
    bit  beam_extreme = 1'b0;

    audio_energy_meter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("audio_energy_meter test failed");
            $finish;
        end
    end

    // receiver: check accepted words, stall in modes set per phase
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(0, 3);
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
                default: begin
                    if ($urandom_range(0, 2) != 0) begin
                        stall_left = $urandom_range(0, 20);
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic send_word(input t_in w);
        if (gap_max > 0 && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic send_group(input t_group_kind kind);
        int  i;
        int  shift;
        t_in w;
        shift = $urandom_range(0, 15);
        for (i = 0; i < GROUP_SIZE; i++) begin
            if (beam_extreme) begin
                case ($urandom_range(0, 3))
                    0:       w.beam_angle = -16'sd32768;
                    1:       w.beam_angle = 16'sd32767;
                    2:       w.beam_angle = 16'sd0;
                    default: w.beam_angle = -16'sd1;
                endcase
                w.beam_confidence = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                w.beam_angle      = 16'($urandom);
                w.beam_confidence = 16'($urandom);
            end
            case (kind)
                GRP_SILENT: w.sample = '0;
                GRP_LOUD:   w.sample = -16'sd32768;
                GRP_PEAK:   w.sample = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
                GRP_TINY:   w.sample = 16'($signed($urandom_range(0, 2)) - 1);
                GRP_RANDOM: w.sample = $signed(16'($urandom)) >>> shift;
                default: begin
                    // per-word amplitude, with the odd full-scale spike
                    if ($urandom_range(0, 15) == 0) w.sample = -16'sd32768;
                    else w.sample = $signed(16'($urandom)) >>> $urandom_range(0, 15);
                end
            endcase
            send_word(w);
        end
        groups_sent++;
    endtask

    function automatic t_group_kind pick_kind(input bit quick);
        int r;
        r = $urandom_range(0, 99);
        if (quick) begin
            if (r < 45) return GRP_SILENT;
            if (r < 90) return GRP_LOUD;
            return GRP_RANDOM;
        end
        if (r < 50) return GRP_RANDOM;
        if (r < 70) return GRP_MIXED;
        if (r < 80) return GRP_TINY;
        if (r < 87) return GRP_SILENT;
        if (r < 94) return GRP_LOUD;
        return GRP_PEAK;
    endfunction

    // hold the sender until every pending group has come out, then let the back end finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_floor(input logic signed [DB_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        sb.set_floor(v);
        cfg_we <= 1'b0;
        floors_set++;
    endtask

    task automatic run_phase(input logic signed [DB_W-1:0] v, input int n_groups);
        int g;
        settle();
        write_floor(v);
        gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        stall_mode = $urandom_range(0, 2);
        for (g = 0; g < n_groups; g++) send_group(pick_kind(1'b0));
    endtask

    initial begin
        int                     ph;
        int                     target;
        logic signed [DB_W-1:0] fl;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset floor, then the floor extremes and out-of-range settings
        beam_extreme = 1'b1;
        send_group(GRP_SILENT);
        send_group(GRP_LOUD);
        send_group(GRP_PEAK);
        send_group(GRP_TINY);
        settle();
        write_floor(-9'sd1);
        send_group(GRP_TINY);
        send_group(GRP_PEAK);
        settle();
        write_floor(-9'sd150);
        send_group(GRP_TINY);
        send_group(GRP_RANDOM);
        settle();
        write_floor(9'sd0);         // non-negative floor forces zero level
        send_group(GRP_RANDOM);
        send_group(GRP_LOUD);
        settle();
        write_floor(9'sd255);
        send_group(GRP_PEAK);
        settle();
        write_floor(-9'sd256);
        send_group(GRP_TINY);
        send_group(GRP_RANDOM);
        beam_extreme = 1'b0;

        // random phases, mostly legal floors
        for (ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 5))
                0:       fl = 9'($urandom);
                1:       fl = ($urandom_range(0, 1)) ? -9'sd1 : -9'sd150;
                default: fl = -$signed(9'($urandom_range(1, 150)));
            endcase
            run_phase(fl, 4);
        end

        // short run of mostly quick groups under light output stalls
        settle();
        write_floor(-9'sd90);
        gap_max    = 2;
        stall_mode = 1;
        target     = groups_sent + 8;
        while (groups_sent < target) send_group(pick_kind(1'b1));

        settle();
        if (sb.pending() != 0) begin
            $error("%0d expected groups never came out", sb.pending());
            sb.errors++;
        end
        $display("Run covered %0d samples in %0d groups over %0d floor settings,",
                 words_sent, groups_sent, floors_set);
        $display("with %0d levels checked and %0d ring slot wraps.",
                 sb.groups_checked, sb.slot_wraps);
        if (sb.errors == 0) begin
            $display("audio_energy_meter test passed");
        end else begin
            $display("audio_energy_meter test failed");
        end
        $finish;
    end
endmodule

[audio_energy_meter.f]
+incdir+src
src/aem_pkg.sv
src/aem_dp.sv
src/aem_ctrl.sv
src/audio_energy_meter.sv
tb/tb.sv
